// File: rtl/cbmi_pkg.sv
// Shared types, codes and helper functions for the cartridge bank mapper core.
// No dependencies; imported by cbmi_bank_store and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cbmi_pkg;

   // word kinds on the request channel (carried in tuser)
   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_TICK  = 2'd1;
   localparam logic [1:0] FUNC_QUERY = 2'd2;

   // register groups, address bits 15..12
   localparam logic [3:0] GROUP_PRG_A = 4'h8;
   localparam logic [3:0] GROUP_CTRL  = 4'h9;
   localparam logic [3:0] GROUP_PRG_B = 4'hA;
   localparam logic [3:0] GROUP_CHR0  = 4'hB;
   localparam logic [3:0] GROUP_CHR1  = 4'hC;
   localparam logic [3:0] GROUP_CHR2  = 4'hD;
   localparam logic [3:0] GROUP_CHR3  = 4'hE;
   localparam logic [3:0] GROUP_IRQ   = 4'hF;

   // sub-register codes in the interrupt group
   localparam logic [1:0] SUB_RELOAD_LO = 2'd0;
   localparam logic [1:0] SUB_RELOAD_HI = 2'd1;
   localparam logic [1:0] SUB_IRQ_CTRL  = 2'd2;
   localparam logic [1:0] SUB_IRQ_ACK   = 2'd3;

   // board wirings of the sub-index address lines
   localparam logic [2:0] WIRING_A2_A1 = 3'd0;
   localparam logic [2:0] WIRING_A0_A1 = 3'd1;
   localparam logic [2:0] WIRING_A7_A6 = 3'd2;
   localparam logic [2:0] WIRING_A2_A3 = 3'd3;
   localparam logic [2:0] WIRING_A3_A2 = 3'd4;

   // configuration register indexes (paddr[3:2])
   localparam logic [1:0] CSR_WIRING   = 2'd0;
   localparam logic [1:0] CSR_PRG_LAST = 2'd1;
   localparam logic [1:0] CSR_CHR_LAST = 2'd2;

   // bank store layout: eight character slots, then the swappable program
   // slot and program slot 1. The fixed program slots are derived.
   localparam int BANK_DEPTH = 10;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);
   localparam logic [BANK_AW-1:0] ENTRY_PRG_VAR = BANK_AW'(8);
   localparam logic [BANK_AW-1:0] ENTRY_PRG_ONE = BANK_AW'(9);

   localparam logic [8:0] PRESCALE_PERIOD = 9'd338;
   localparam logic [8:0] PRESCALE_STEP   = 9'd3;
   localparam logic [7:0] COUNTER_MAX     = 8'hFF;

   typedef struct packed {
      logic               en;
      logic [BANK_AW-1:0] addr;
   } bank_rd_type;

   typedef struct packed {
      logic               en;
      logic [BANK_AW-1:0] addr;
      logic [7:0]         data;
   } bank_wr_type;

   function automatic logic [7:0] bank_reset_value(input logic [BANK_AW-1:0] addr);
      logic [7:0] v;
      if (addr == ENTRY_PRG_VAR) begin
         v = 8'd0;
      end else if (addr == ENTRY_PRG_ONE) begin
         v = 8'd1;
      end else begin
         v = 8'(addr);
      end
      return v;
   endfunction

   function automatic logic [1:0] decode_sub(input logic [2:0] wiring,
                                             input logic [15:0] addr);
      logic [1:0] s;
      unique case (wiring)
         WIRING_A2_A1: s = addr[2:1];
         WIRING_A0_A1: s = {addr[0], addr[1]};
         WIRING_A7_A6: s = addr[7:6];
         WIRING_A2_A3: s = {addr[2], addr[3]};
         WIRING_A3_A2: s = addr[3:2];
         default:      s = addr[2:1];
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// File: rtl/cbmi_bank_store.sv
// Bank store: synchronous memory of slot banks with registered read data,
// per-entry valid bits for reset values and write-to-read forwarding. Uses cbmi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbmi_bank_store
   import cbmi_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire bank_rd_type rd,
   input  wire bank_wr_type wr,
   output logic [7:0]       rd_data
);

   logic [7:0]         bank_mem_ff [BANK_DEPTH];
   logic [7:0]         mem_q_ff;
   logic [BANK_DEPTH-1:0] valid_ff;
   logic               hit_valid_ff;
   logic               fwd_ff;
   logic [7:0]         fwd_data_ff;
   logic [BANK_AW-1:0] rd_addr_q_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         bank_mem_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         mem_q_ff     <= bank_mem_ff[rd.addr];
         fwd_data_ff  <= wr.data;
         rd_addr_q_ff <= rd.addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         hit_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd.en) begin
            hit_valid_ff <= valid_ff[rd.addr];
            // write landing in the same cycle as the read
            fwd_ff       <= wr.en && (wr.addr == rd.addr);
         end
      end
   end

   assign rd_data = fwd_ff       ? fwd_data_ff :
                    hit_valid_ff ? mem_q_ff    : bank_reset_value(rd_addr_q_ff);

endmodule

`default_nettype wire

// File: rtl/cartridge_bank_mapper_irq_core.sv
// Top level of the cartridge bank mapper with interrupt counter.
// Uses cbmi_pkg and cbmi_bank_store.
//
//  port group   role        fields
//  req_*        stream in   tuser: func; tdata: address, value, query_slot
//  rsp_*        stream out  tdata: bank, irq_pending, mirror_mode, prg_swapped
//  csr_*        APB slave   wiring, last program bank, last character bank
//
// One word per clock sustained while rsp_tready stays high. The bank store read is issued in the accept
// cycle, the word then passes through the update stage and sits in the output register.
// rsp_tvalid comes from the output register, which is loaded when the update stage fires.
// Reset is synchronous; stored banks read as their reset values until written.
// A stalled rsp_tready backs up the update stage and then req_tready.
`timescale 1ns / 1ps
`default_nettype none

module cartridge_bank_mapper_irq_core
   import cbmi_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // [15:0] address, [23:16] value, [27:24] query_slot
   input  wire logic [1:0]  req_tuser,  // [1:0] func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // [7:0] bank, [8] irq_pending, [10:9] mirror_mode,
                                        // [11] prg_swapped
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // configuration
   logic [2:0] wiring_ff;
   logic [4:0] prg_last_ff;
   logic [7:0] chr_last_ff;

   // update stage
   logic       s1_valid_ff;
   logic [1:0] s1_func_ff;
   logic       s1_hi_ff;
   logic [3:0] s1_group_ff;
   logic [1:0] s1_sub_ff;
   logic [7:0] s1_value_ff;
   logic [3:0] s1_slot_ff;

   // scalar state
   logic       swap_ff, swap_in;
   logic [1:0] mirror_ff, mirror_in;
   logic [7:0] reload_ff, reload_in;
   logic [7:0] counter_ff, counter_in;
   logic [8:0] prescale_ff, prescale_in;
   logic       irq_en_ff, irq_en_in;
   logic       cycle_mode_ff, cycle_mode_in;
   logic       ack_en_ff, ack_en_in;
   logic       irq_line_ff, irq_line_in;

   // output register
   logic       rsp_valid_ff;
   logic [7:0] rsp_bank_ff, rsp_bank_in;

   logic        req_fire;
   logic        s1_fire;
   logic        csr_write;
   logic [1:0]  req_sub;
   logic [15:0] req_address;
   logic [3:0]  req_slot;
   bank_rd_type bank_rd;
   bank_wr_type bank_wr;
   logic [7:0]  bank_q;
   logic [4:0]  second_last;
   logic [4:0]  prg_clamped;
   logic [7:0]  chr_new;

   assign req_address = req_tdata[15:0];
   assign req_slot    = req_tdata[27:24];
   assign req_sub     = decode_sub(wiring_ff, req_address);

   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wiring_ff   <= 3'd0;
         prg_last_ff <= 5'd31;
         chr_last_ff <= 8'd255;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            CSR_WIRING:   wiring_ff   <= csr_pwdata[2:0];
            CSR_PRG_LAST: prg_last_ff <= csr_pwdata[4:0];
            CSR_CHR_LAST: chr_last_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         CSR_WIRING:   csr_prdata = {29'd0, wiring_ff};
         CSR_PRG_LAST: csr_prdata = {27'd0, prg_last_ff};
         CSR_CHR_LAST: csr_prdata = {24'd0, chr_last_ff};
         default:      csr_prdata = 32'd0;
      endcase
   end

   // ---------------- bank store read at accept ----------------
   always_comb begin
      bank_rd.en   = req_fire;
      bank_rd.addr = ENTRY_PRG_VAR;
      if (req_tuser == FUNC_WRITE) begin
         // character groups: slot from group offset and sub bit 1
         bank_rd.addr = {1'b0, 2'(req_address[15:12] - GROUP_CHR0), req_sub[1]};
      end else if (req_tuser == FUNC_QUERY) begin
         if (req_slot == 4'd1) begin
            bank_rd.addr = ENTRY_PRG_ONE;
         end else if (req_slot >= 4'd4 && req_slot < 4'd12) begin
            bank_rd.addr = {1'b0, 3'(req_slot - 4'd4)};
         end
      end
   end

   cbmi_bank_store u_bank_store (
      .clock   (clock),
      .reset   (reset),
      .rd      (bank_rd),
      .wr      (bank_wr),
      .rd_data (bank_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_func_ff  <= req_tuser;
         s1_hi_ff    <= req_address[15];
         s1_group_ff <= req_address[15:12];
         s1_sub_ff   <= req_sub;
         s1_value_ff <= req_tdata[23:16];
         s1_slot_ff  <= req_slot;
      end
   end

   // ---------------- update stage ----------------
   assign second_last = prg_last_ff - 5'd1;

   always_comb begin
      prg_clamped = s1_value_ff[4:0];
      if (prg_clamped > prg_last_ff) begin
         prg_clamped = prg_clamped & prg_last_ff;
      end
      chr_new = s1_sub_ff[0] ? {s1_value_ff[3:0], bank_q[3:0]}
                             : {bank_q[7:4], s1_value_ff[3:0]};
      if (chr_new > chr_last_ff) begin
         chr_new = chr_new & chr_last_ff;
      end
   end

   always_comb begin
      swap_in       = swap_ff;
      mirror_in     = mirror_ff;
      reload_in     = reload_ff;
      counter_in    = counter_ff;
      prescale_in   = prescale_ff;
      irq_en_in     = irq_en_ff;
      cycle_mode_in = cycle_mode_ff;
      ack_en_in     = ack_en_ff;
      irq_line_in   = irq_line_ff;
      bank_wr.en    = 1'b0;
      bank_wr.addr  = ENTRY_PRG_VAR;
      bank_wr.data  = {3'd0, prg_clamped};
      rsp_bank_in   = 8'd0;

      if (s1_fire) begin
         unique case (s1_func_ff)
            FUNC_WRITE: begin
               if (s1_hi_ff) begin
                  case (s1_group_ff) inside
                     GROUP_PRG_A: begin
                        bank_wr.en = 1'b1;
                     end
                     GROUP_PRG_B: begin
                        bank_wr.en   = 1'b1;
                        bank_wr.addr = ENTRY_PRG_ONE;
                     end
                     GROUP_CTRL: begin
                        if (!s1_sub_ff[1]) begin
                           mirror_in = s1_value_ff[1:0];
                        end else begin
                           // fixed slot follows the swap, so only the flag moves
                           swap_in = s1_value_ff[1];
                        end
                     end
                     GROUP_CHR0, GROUP_CHR1, GROUP_CHR2, GROUP_CHR3: begin
                        bank_wr.en   = 1'b1;
                        bank_wr.addr = {1'b0, 2'(s1_group_ff - GROUP_CHR0), s1_sub_ff[1]};
                        bank_wr.data = chr_new;
                     end
                     GROUP_IRQ: begin
                        unique case (s1_sub_ff)
                           SUB_RELOAD_LO: reload_in = {reload_ff[7:4], s1_value_ff[3:0]};
                           SUB_RELOAD_HI: reload_in = {s1_value_ff[3:0], reload_ff[3:0]};
                           SUB_IRQ_CTRL: begin
                              ack_en_in     = s1_value_ff[0];
                              irq_en_in     = s1_value_ff[1];
                              cycle_mode_in = s1_value_ff[2];
                              if (s1_value_ff[1]) begin
                                 prescale_in = 9'd0;
                                 counter_in  = reload_ff;
                              end
                              irq_line_in = 1'b0;
                           end
                           SUB_IRQ_ACK: begin
                              irq_en_in   = ack_en_ff;
                              irq_line_in = 1'b0;
                           end
                           default: ;
                        endcase
                     end
                     default: ;
                  endcase
               end
            end
            FUNC_TICK: begin
               if (irq_en_ff) begin
                  if (!cycle_mode_ff && prescale_ff < PRESCALE_PERIOD) begin
                     prescale_in = prescale_ff + PRESCALE_STEP;
                  end else begin
                     if (!cycle_mode_ff) begin
                        prescale_in = prescale_ff - PRESCALE_PERIOD;
                     end
                     if (counter_ff != COUNTER_MAX) begin
                        counter_in = counter_ff + 8'd1;
                     end else begin
                        counter_in  = reload_ff;
                        irq_line_in = 1'b1;
                     end
                  end
               end
            end
            FUNC_QUERY: begin
               case (s1_slot_ff)
                  4'd0:    rsp_bank_in = swap_ff ? {3'd0, second_last} : bank_q;
                  4'd1:    rsp_bank_in = bank_q;
                  4'd2:    rsp_bank_in = swap_ff ? bank_q : {3'd0, second_last};
                  4'd3:    rsp_bank_in = {3'd0, prg_last_ff};
                  4'd12, 4'd13, 4'd14, 4'd15: rsp_bank_in = 8'd0;
                  default: rsp_bank_in = bank_q;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff       <= 1'b0;
         mirror_ff     <= 2'd0;
         reload_ff     <= 8'd0;
         counter_ff    <= 8'd0;
         prescale_ff   <= 9'd0;
         irq_en_ff     <= 1'b0;
         cycle_mode_ff <= 1'b0;
         ack_en_ff     <= 1'b0;
         irq_line_ff   <= 1'b0;
      end else begin
         swap_ff       <= swap_in;
         mirror_ff     <= mirror_in;
         reload_ff     <= reload_in;
         counter_ff    <= counter_in;
         prescale_ff   <= prescale_in;
         irq_en_ff     <= irq_en_in;
         cycle_mode_ff <= cycle_mode_in;
         ack_en_ff     <= ack_en_in;
         irq_line_ff   <= irq_line_in;
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   logic [3:0] rsp_flags_ff;

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_bank_ff  <= rsp_bank_in;
         rsp_flags_ff <= {swap_in, mirror_in, irq_line_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_flags_ff, rsp_bank_ff};

   // ---------------- checks ----------------
   a_backpressure_source: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_valid_ff && !rsp_tready))
      else $error("request stalled without output backpressure");

   a_irq_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(irq_line_ff) |-> $past(s1_fire && (s1_func_ff == FUNC_TICK)))
      else $error("interrupt line rose without a tick");

   a_prescale_range: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> (prescale_ff <= (PRESCALE_PERIOD + PRESCALE_STEP - 9'd1)))
      else $error("prescaler out of range");

   a_word_lands: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("update stage fired but output register empty");

endmodule

`default_nettype wire

// File: bench/cartridge_bank_mapper_irq_core_tb.sv
// Self-checking bench for cartridge_bank_mapper_irq_core: stream words in,
// status words out, APB writes of wiring and last-bank registers between phases.
// Depends on cbmi_pkg and the RTL of the core; predictor is a class in this file.
`timescale 1ns / 1ps

module cartridge_bank_mapper_irq_core_tb;
   import cbmi_pkg::*;

   localparam logic [1:0] FUNC_NOP  = 2'd3;  // unused kind, must still answer
   localparam int         HOLD_LEN  = 300;
   localparam int         STALL_MAX = 5000;
   localparam int         PHASES    = 8;
   localparam int         PHASE_LEN = 180;

   // result word as it sits in rsp_tdata
   typedef struct packed {
      logic [3:0] pad;
      logic       swapped;
      logic [1:0] mirror;
      logic       irq;
      logic [7:0] bank;
   } map_status_type;

   class mapper_scoreboard;
      logic [2:0]  wiring;
      logic [4:0]  prg_last;
      logic [7:0]  chr_last;
      logic [4:0]  prg_bank[4];
      logic [7:0]  chr_bank[8];
      logic        swap;
      logic [1:0]  mirror;
      logic [7:0]  reload;
      logic [7:0]  counter;
      logic [8:0]  prescale;
      logic        irq_en;
      logic        cycle_mode;
      logic        en_after_ack;
      logic        irq_line;
      map_status_type status_q[$];
      int          errors;

      function new();
         errors = 0;
         wiring = WIRING_A2_A1;
         prg_last = 5'd31;
         chr_last = 8'd255;
         swap = 1'b0;
         prg_bank[0] = 5'd0;
         prg_bank[1] = 5'd1;
         place_fixed();
         for (int i = 0; i < 8; i++) chr_bank[i] = 8'(i);
         mirror = 2'd0;
         reload = 8'd0;
         counter = 8'd0;
         prescale = 9'd0;
         irq_en = 1'b0;
         cycle_mode = 1'b0;
         en_after_ack = 1'b0;
         irq_line = 1'b0;
      endfunction

      function int pending();
         return status_q.size();
      endfunction

      // last bank in slot 3, second-last opposite the swappable slot
      function void place_fixed();
         prg_bank[3] = prg_last;
         if (swap) prg_bank[0] = prg_last - 5'd1;
         else prg_bank[2] = prg_last - 5'd1;
      endfunction

      // address lines that carry sub[1] and sub[0] for a board wiring
      function void sub_lines(input logic [2:0] w, output int hi, output int lo);
         case (w)
            WIRING_A0_A1: begin hi = 0; lo = 1; end
            WIRING_A7_A6: begin hi = 7; lo = 6; end
            WIRING_A2_A3: begin hi = 2; lo = 3; end
            WIRING_A3_A2: begin hi = 3; lo = 2; end
            default:      begin hi = 2; lo = 1; end
         endcase
      endfunction

      function logic [4:0] clamp_prg(logic [7:0] v);
         logic [4:0] b;
         b = v[4:0];
         if (b > prg_last) b = b & prg_last;
         return b;
      endfunction

      function void csr_write(logic [1:0] idx, logic [31:0] d);
         case (idx)
            CSR_WIRING:   wiring = d[2:0];
            CSR_PRG_LAST: begin
               prg_last = d[4:0];
               place_fixed();
            end
            CSR_CHR_LAST: chr_last = d[7:0];
            default: ;
         endcase
      endfunction

      function void reg_write(logic [15:0] a, logic [7:0] v);
         logic [3:0] group;
         logic [1:0] sub;
         logic [2:0] slot;
         logic [7:0] nv;
         logic [4:0] t;
         int         hi, lo;
         sub_lines(wiring, hi, lo);
         sub = {a[hi], a[lo]};
         group = a[15:12];
         case (group)
            GROUP_PRG_A: begin
               if (swap) prg_bank[2] = clamp_prg(v);
               else prg_bank[0] = clamp_prg(v);
               if (swap) prg_bank[0] = prg_last - 5'd1;
               else prg_bank[2] = prg_last - 5'd1;
            end
            GROUP_PRG_B: prg_bank[1] = clamp_prg(v);
            GROUP_CTRL: begin
               if (!sub[1]) begin
                  mirror = v[1:0];
               end else if (v[1] != swap) begin
                  t = prg_bank[0];
                  prg_bank[0] = prg_bank[2];
                  prg_bank[2] = t;
                  swap = v[1];
               end
            end
            GROUP_CHR0, GROUP_CHR1, GROUP_CHR2, GROUP_CHR3: begin
               slot = {2'(group - GROUP_CHR0), sub[1]};
               nv = chr_bank[slot];
               if (sub[0]) nv[7:4] = v[3:0];
               else nv[3:0] = v[3:0];
               if (nv > chr_last) nv = nv & chr_last;
               chr_bank[slot] = nv;
            end
            GROUP_IRQ: begin
               case (sub)
                  SUB_RELOAD_LO: reload[3:0] = v[3:0];
                  SUB_RELOAD_HI: reload[7:4] = v[3:0];
                  SUB_IRQ_CTRL: begin
                     en_after_ack = v[0];
                     irq_en = v[1];
                     cycle_mode = v[2];
                     if (irq_en) begin
                        prescale = 9'd0;
                        counter = reload;
                     end
                     irq_line = 1'b0;
                  end
                  default: begin
                     irq_en = en_after_ack;
                     irq_line = 1'b0;
                  end
               endcase
            end
            default: ;
         endcase
      endfunction

      function void tick_counter();
         if (!irq_en) return;
         if (!cycle_mode) begin
            if (prescale < PRESCALE_PERIOD) begin
               prescale = prescale + PRESCALE_STEP;
               return;
            end
            prescale = prescale - PRESCALE_PERIOD;
         end
         if (counter != COUNTER_MAX) begin
            counter = counter + 8'd1;
         end else begin
            counter = reload;
            irq_line = 1'b1;
         end
      endfunction

      function void note_word(logic [1:0] func, logic [15:0] a, logic [7:0] v,
                              logic [3:0] slot);
         map_status_type s;
         s = '0;
         case (func)
            FUNC_WRITE: if (a[15]) reg_write(a, v);
            FUNC_TICK:  tick_counter();
            FUNC_QUERY: begin
               if (slot < 4) s.bank = {3'd0, prg_bank[slot[1:0]]};
               else if (slot < 12) s.bank = chr_bank[3'(slot - 4'd4)];
            end
            default: ;
         endcase
         s.irq = irq_line;
         s.mirror = mirror;
         s.swapped = swap;
         status_q.push_back(s);
      endfunction

      function void flag(string what, int want, int got);
         errors++;
         if (errors <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      endfunction

      function void check_word(logic [15:0] word);
         map_status_type got, want;
         got = word;
         if (status_q.size() == 0) begin
            flag("unexpected word", 0, word);
            return;
         end
         want = status_q.pop_front();
         if (got.bank !== want.bank) flag("bank", want.bank, got.bank);
         if (got.irq !== want.irq) flag("irq_pending", want.irq, got.irq);
         if (got.mirror !== want.mirror) flag("mirror_mode", want.mirror, got.mirror);
         if (got.swapped !== want.swapped) flag("prg_swapped", want.swapped, got.swapped);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [15:0] address, [23:16] value, [27:24] query_slot
   logic [1:0]  req_tuser;   // [1:0] func
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [7:0] bank, [8] irq_pending, [10:9] mirror_mode, [11] prg_swapped
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   mapper_scoreboard sb;
   bit               calm;
   bit               hold_off;
   int               stall_cycles;

   int cfg_wiring[PHASES] = '{1, 2, 3, 4, 5, 0, 7, 6};
   int cfg_prg[PHASES]    = '{15, 0, 31, 1, 20, 31, 3, 16};
   int cfg_chr[PHASES]    = '{100, 0, 255, 7, 128, 255, 200, 15};

   cartridge_bank_mapper_irq_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // monitor: feeds the predictor, checks results, watches for a hang
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            sb.csr_write(csr_paddr[3:2], csr_pwdata);
         if (req_tvalid && req_tready)
            sb.note_word(req_tuser, req_tdata[15:0], req_tdata[23:16], req_tdata[27:24]);
         if (rsp_tvalid && rsp_tready)
            sb.check_word(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= STALL_MAX) begin
            $display("Some tests failed");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // receiver: random back-pressure, plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_LEN) @(negedge clock);
            hold_off = 1'b0;
         end
         rsp_tready <= calm || ($urandom_range(99) >= 20);
      end
   end

   // called at a falling edge, returns at the falling edge after the accept
   task automatic send_word(logic [1:0] func, logic [15:0] a, logic [7:0] v,
                            logic [3:0] slot);
      while (!calm && $urandom_range(99) < 20) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {4'd0, slot, v, a};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] d);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= d;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic drain(int extra);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
      @(negedge clock);
   endtask

   // register address for the current wiring, other bits random
   function automatic logic [15:0] reg_addr(logic [3:0] group, logic [1:0] sub);
      logic [15:0] a;
      int          hi, lo;
      a = 16'($urandom);
      a[15:12] = group;
      sb.sub_lines(sb.wiring, hi, lo);
      a[hi] = sub[1];
      a[lo] = sub[0];
      return a;
   endfunction

   task automatic random_word();
      int          r, gi;
      logic [1:0]  f;
      logic [15:0] a;
      logic [7:0]  v;
      logic [3:0]  s;
      logic [3:0]  g;
      logic [1:0]  sub;
      r = $urandom_range(99);
      a = 16'($urandom);
      v = 8'($urandom);
      s = 4'($urandom);
      if (r < 40) begin
         f = FUNC_TICK;
      end else if (r < 55) begin
         f = FUNC_QUERY;
      end else if (r < 59) begin
         f = FUNC_NOP;
      end else begin
         f = FUNC_WRITE;
         if (r < 64) begin
            a[15] = 1'b0;
         end else begin
            gi = $urandom_range(8, 16);
            g = (gi > 15) ? GROUP_IRQ : 4'(gi);
            sub = 2'($urandom);
            // high reloads make overflow reachable in cycle mode
            if (g == GROUP_IRQ && sub == SUB_RELOAD_HI && $urandom_range(1)) v[3:0] = 4'hF;
            a = reg_addr(g, sub);
         end
      end
      send_word(f, a, v, s);
   endtask

   // scanline prescaler: reload 0xFF so every prescaler wrap overflows
   task automatic scanline_burst();
      send_word(FUNC_WRITE, reg_addr(GROUP_IRQ, SUB_RELOAD_LO), 8'h0F, 4'd0);
      send_word(FUNC_WRITE, reg_addr(GROUP_IRQ, SUB_RELOAD_HI), 8'h0F, 4'd0);
      send_word(FUNC_WRITE, reg_addr(GROUP_IRQ, SUB_IRQ_CTRL), 8'h03, 4'd0);
      repeat (240) send_word(FUNC_TICK, 16'($urandom), 8'($urandom), 4'($urandom));
      send_word(FUNC_WRITE, reg_addr(GROUP_IRQ, SUB_IRQ_ACK), 8'h00, 4'd0);
      repeat (20) send_word(FUNC_TICK, 16'($urandom), 8'($urandom), 4'($urandom));
   endtask

   initial begin
      sb = new();
      calm = 1'b0;
      hold_off = 1'b0;
      stall_cycles = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = FUNC_WRITE;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part under reset configuration, wiring A2:A1
      send_word(FUNC_QUERY, 16'h0000, 8'h00, 4'd0);
      send_word(FUNC_QUERY, 16'hFFFF, 8'hFF, 4'd3);
      send_word(FUNC_QUERY, 16'h0000, 8'h00, 4'd4);
      send_word(FUNC_QUERY, 16'h0000, 8'h00, 4'd11);
      send_word(FUNC_QUERY, 16'h0000, 8'h00, 4'd12);
      send_word(FUNC_QUERY, 16'h0000, 8'h00, 4'd15);
      send_word(FUNC_NOP, 16'hFFFF, 8'hFF, 4'hF);
      send_word(FUNC_WRITE, 16'h7FFF, 8'hFF, 4'd0);     // below the register window
      send_word(FUNC_WRITE, 16'h8000, 8'hFF, 4'd0);
      send_word(FUNC_WRITE, 16'hA000, 8'h3F, 4'd0);
      send_word(FUNC_WRITE, 16'h9000, 8'h03, 4'd0);
      send_word(FUNC_WRITE, 16'h9004, 8'h02, 4'd0);     // swap on
      send_word(FUNC_WRITE, 16'hB000, 8'hFF, 4'd0);
      send_word(FUNC_WRITE, 16'hB002, 8'hFF, 4'd0);
      send_word(FUNC_WRITE, 16'hF000, 8'h0E, 4'd0);
      send_word(FUNC_WRITE, 16'hF002, 8'h0F, 4'd0);
      send_word(FUNC_WRITE, 16'hF004, 8'h06, 4'd0);     // enable, cycle mode
      repeat (3) send_word(FUNC_TICK, 16'h0000, 8'h00, 4'd0);
      send_word(FUNC_WRITE, 16'hF006, 8'h00, 4'd0);     // ack, disables
      send_word(FUNC_TICK, 16'h0000, 8'h00, 4'd0);
      send_word(FUNC_QUERY, 16'h0000, 8'h00, 4'd0);
      send_word(FUNC_QUERY, 16'h0000, 8'h00, 4'd2);

      for (int p = 0; p < PHASES; p++) begin
         drain(4);
         csr_write(CSR_WIRING, 32'(cfg_wiring[p]));
         csr_write(CSR_PRG_LAST, 32'(cfg_prg[p]));
         csr_write(CSR_CHR_LAST, 32'(cfg_chr[p]));
         calm = (p == 3);
         if (p == 5) hold_off = 1'b1;
         if (p == 2) scanline_burst();
         repeat (PHASE_LEN) random_word();
      end

      drain(10);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
